// File: src/twp_pkg.sv
// Shared types and constants for the time-window primitive packetizer.
// No dependencies; every other file of the block imports this package.
package twp_pkg;

  localparam int MAX_ENTRIES_DEF = 63;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ENTRY_W = 56;
  localparam int WORD_W  = 64;
  localparam int TS_W    = 32;
  localparam int ID_W    = 16;
  localparam int FINE_W  = 8;
  localparam int SRC_W   = 8;
  localparam int WIN_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd1;

  localparam logic [SRC_W-1:0] SOURCE_ID_RST    = 8'h30;
  localparam logic [WIN_W-1:0] WINDOW_TICKS_RST = 16'd255;

  // Entry layout from the lowest bit: fine time, primitive ID, timestamp.
  typedef struct packed {
    logic [TS_W-1:0]   time_stamp;
    logic [ID_W-1:0]   primitive_id;
    logic [FINE_W-1:0] fine_time;
  } twp_entry_t;

  // A request from the front to the back: append the entry, or first flush
  // the buffered packet and then start a new one with the entry.
  typedef struct packed {
    logic       close;
    twp_entry_t entry;
  } twp_cmd_t;

endpackage

// File: src/time_window_primitive_packetizer_core.sv
// Time-window primitive packetizer: configuration registers, front end,
// request queue and packet back end. Depends on twp_pkg and all twp_ modules.
// Throughput: one primitive per cycle while no packet drains; a closing
// request holds the back end while it takes the request and then sends the
// header and n entries, one word per cycle while the output is not stalled,
// paced by the single read port of the entry buffer.
// A closing primitive passes the request queue into the back end's header
// state, which loads the header into the output register. Reset (rst_n low,
// synchronous) clears all control state and loads source_id 0x30 and
// window_ticks 255; buffer contents stay undefined until written.
module time_window_primitive_packetizer_core #(
  parameter int MAX_ENTRIES = twp_pkg::MAX_ENTRIES_DEF,
  parameter int QUEUE_DEPTH = twp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // primitive_id [15:0], fine_time [23:16], time_stamp [55:24]
  input  logic [twp_pkg::ENTRY_W-1:0]    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // packet_word [63:0]
  output logic [twp_pkg::WORD_W-1:0]     out_tdata,
  // is_header [0]
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [twp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [twp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import twp_pkg::*;

  logic [SRC_W-1:0] source_id_r;
  logic [WIN_W-1:0] window_ticks_r;
  twp_entry_t       in_entry;
  twp_cmd_t         push_data;
  twp_cmd_t         pop_data;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_valid;

  assign in_entry = {in_tdata[55:24], in_tdata[15:0], in_tdata[23:16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_id_r    <= SOURCE_ID_RST;
      window_ticks_r <= WINDOW_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SOURCE_ID:    source_id_r    <= cfg_wdata[SRC_W-1:0];
        REG_WINDOW_TICKS: window_ticks_r <= cfg_wdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  twp_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_entry     (in_entry),
    .window_ticks (window_ticks_r),
    .cmd_push     (cmd_push),
    .cmd_data     (push_data),
    .cmd_full     (cmd_full)
  );

  twp_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (push_data),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (pop_data),
    .not_empty (cmd_valid)
  );

  twp_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .source_id     (source_id_r),
    .cmd_valid     (cmd_valid),
    .cmd_data      (pop_data),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_word      (out_tdata),
    .out_is_header (out_tuser),
    .out_last      (out_tlast)
  );

endmodule

// File: src/twp_cmd_fifo.sv
// Short request queue between the classifying front and the packet back end.
// Depends on twp_pkg for the request type.
module twp_cmd_fifo #(
  parameter int DEPTH = twp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  twp_pkg::twp_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output twp_pkg::twp_cmd_t pop_data,
  output logic              not_empty
);
  import twp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  twp_cmd_t         slots_r [DEPTH];
  logic [PTR_W:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   ptr_diff;

  assign ptr_diff   = wr_ptr_r - rd_ptr_r;
  assign full       = (ptr_diff == (PTR_W + 1)'(DEPTH));
  assign not_empty  = (ptr_diff != '0);
  assign pop_data   = slots_r[rd_ptr_r[PTR_W-1:0]];
  assign wr_ptr_nxt = wr_ptr_r + (PTR_W + 1)'(push && !full);
  assign rd_ptr_nxt = rd_ptr_r + (PTR_W + 1)'(pop && not_empty);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots_r[wr_ptr_r[PTR_W-1:0]] <= push_data;
    end
  end

endmodule

// File: src/twp_front.sv
// Front end: accepts primitives, checks the time window and buffer fill, and
// queues append or close requests. Depends on twp_pkg.
module twp_front #(
  parameter int MAX_ENTRIES = twp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  twp_pkg::twp_entry_t       in_entry,
  input  logic [twp_pkg::WIN_W-1:0] window_ticks,
  output logic                      cmd_push,
  output twp_pkg::twp_cmd_t         cmd_data,
  input  logic                      cmd_full
);
  import twp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W-1:0]  win_start_r, win_start_nxt;
  logic [TS_W-1:0]  diff;
  logic             beyond;
  logic             close;
  logic             accept;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && !cmd_full;
  assign diff     = in_entry.time_stamp - win_start_r;
  assign beyond   = diff > {{(TS_W - WIN_W){1'b0}}, window_ticks};
  assign close    = (cnt_r != '0) && (beyond || (cnt_r >= CNT_W'(MAX_ENTRIES)));

  assign cmd_push       = accept;
  assign cmd_data.close = close;
  assign cmd_data.entry = in_entry;

  always_comb begin
    cnt_nxt       = cnt_r;
    win_start_nxt = win_start_r;
    if (accept) begin
      if (cnt_r == '0) begin
        cnt_nxt = CNT_W'(1);
        if (beyond) begin
          win_start_nxt = in_entry.time_stamp;
        end
      end else if (close) begin
        cnt_nxt       = CNT_W'(1);
        win_start_nxt = in_entry.time_stamp;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      win_start_r <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      win_start_r <= win_start_nxt;
    end
  end

endmodule

// File: src/twp_back.sv
// Back end: holds the entry buffer, and on a close request sends the header
// and every buffered entry through the output register. Depends on twp_pkg.
module twp_back #(
  parameter int MAX_ENTRIES = twp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [twp_pkg::SRC_W-1:0]  source_id,
  input  logic                       cmd_valid,
  input  twp_pkg::twp_cmd_t          cmd_data,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [twp_pkg::WORD_W-1:0] out_word,
  output logic                       out_is_header,
  output logic                       out_last
);
  import twp_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_ENT  = 2'd2;

  twp_entry_t       buf_mem [MAX_ENTRIES];
  twp_entry_t       rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  twp_entry_t       mem_wdata;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_pos_r, rd_pos_nxt;
  logic [23:0]      ts0_r, ts0_nxt;
  twp_entry_t       pend_r, pend_nxt;

  logic             ov_r, ov_nxt;
  logic [WORD_W-1:0] ow_r, ow_nxt;
  logic             oh_r, oh_nxt;
  logic             ol_r, ol_nxt;
  logic             slot_free;

  logic [7:0]       n8;
  logic [15:0]      len16;
  logic [WORD_W-1:0] hdr_word;
  logic [WORD_W-1:0] ent_word;
  logic             is_last;

  assign out_valid     = ov_r;
  assign out_word      = ow_r;
  assign out_is_header = oh_r;
  assign out_last      = ol_r;
  assign slot_free     = !ov_r || out_ready;

  assign n8       = 8'(cnt_r);
  assign len16    = {5'd0, n8, 3'b000} + 16'd8;
  assign hdr_word = {source_id, n8, len16, source_id, ts0_r};
  assign ent_word = {rd_data_r.time_stamp, rd_data_r.primitive_id, 8'h00,
                     rd_data_r.fine_time};
  assign is_last  = (rd_pos_r + CNT_W'(1)) == cnt_r;
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rd_pos_nxt = rd_pos_r;
    ts0_nxt    = ts0_r;
    pend_nxt   = pend_r;
    mem_we     = 1'b0;
    mem_waddr  = cnt_r[IDX_W-1:0];
    mem_wdata  = cmd_data.entry;
    ov_nxt     = ov_r && !out_ready;
    ow_nxt     = ow_r;
    oh_nxt     = oh_r;
    ol_nxt     = ol_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd_data.close) begin
            pend_nxt  = cmd_data.entry;
            state_nxt = ST_HDR;
          end else begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_r == '0) begin
              ts0_nxt = cmd_data.entry.time_stamp[23:0];
            end
          end
        end
      end
      ST_HDR: begin
        rd_pos_nxt = '0;
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ow_nxt    = hdr_word;
          oh_nxt    = 1'b1;
          ol_nxt    = 1'b0;
          state_nxt = ST_ENT;
        end
      end
      ST_ENT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ow_nxt = ent_word;
          oh_nxt = 1'b0;
          ol_nxt = is_last;
          if (is_last) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = pend_r;
            cnt_nxt   = CNT_W'(1);
            ts0_nxt   = pend_r.time_stamp[23:0];
            state_nxt = ST_IDLE;
          end else begin
            rd_pos_nxt = rd_pos_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= buf_mem[rd_pos_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      rd_pos_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_pos_r <= rd_pos_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ts0_r  <= ts0_nxt;
    pend_r <= pend_nxt;
    ow_r   <= ow_nxt;
    oh_r   <= oh_nxt;
    ol_r   <= ol_nxt;
  end

endmodule
